// ----- hw/rtl/lpd_pkg.sv -----
// Shared types and constants for the Legendre polynomial evaluator.
// Holds the controller states and the command and status bundles between
// the controller and the datapath. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

  localparam int FRAC_BITS = 30;
  localparam int ORDER_W   = 6;
  localparam int MU_W      = 32;
  localparam int SLOPE_W   = 42;

  localparam logic signed [MU_W-1:0] ONE_Q = MU_W'(64'sd1 << FRAC_BITS);

  // Recurrence division by k: 40-bit dividend, eight quotient bits a cycle.
  localparam int QDIV_W      = 40;
  localparam int QDIV_BITS   = 8;
  localparam int QDIV_CHUNKS = QDIV_W / QDIV_BITS;

  // Slope division: one quotient bit a cycle, quotient below 2^43.
  localparam int DDIV_STEPS = 43;

  localparam int CNT_W = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP_MUL,
    ST_STEP_T,
    ST_STEP_LOAD,
    ST_STEP_DIV,
    ST_STEP_UPD,
    ST_DER_MUL1,
    ST_DER_NUM,
    ST_DER_MUL2,
    ST_DER_CHECK,
    ST_DER_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic mul_sel_mu;
    logic t_en;
    logic qd_load;
    logic qd_step;
    logic upd;
    logic num_en;
    logic chk_en;
    logic dd_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic k_last;
    logic der_skip;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lpd_ctrl.sv -----
// Controller state machine for the Legendre polynomial evaluator.
// Sequences the recurrence steps, the slope division and the result hand-off.
// Depends on lpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output lpd_pkg::cmd_t    cmd,
  input  lpd_pkg::status_t status
);
  import lpd_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_STEP_MUL;
      end
      ST_STEP_MUL: begin
        // Orders zero and one need no recurrence step and no division.
        if (status.n_lt2) state_next = ST_FIN;
        else              state_next = ST_STEP_T;
      end
      ST_STEP_T: state_next = ST_STEP_LOAD;
      ST_STEP_LOAD: begin
        state_next = ST_STEP_DIV;
        cnt_next   = '0;
      end
      ST_STEP_DIV: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(QDIV_CHUNKS - 1)) state_next = ST_STEP_UPD;
      end
      ST_STEP_UPD: begin
        if (status.k_last) state_next = ST_DER_MUL1;
        else               state_next = ST_STEP_MUL;
      end
      ST_DER_MUL1: state_next = ST_DER_NUM;
      ST_DER_NUM:  state_next = ST_DER_MUL2;
      ST_DER_MUL2: state_next = ST_DER_CHECK;
      ST_DER_CHECK: begin
        state_next = ST_DER_DIV;
        cnt_next   = '0;
      end
      ST_DER_DIV: begin
        cnt_next = cnt + CNT_W'(1);
        if (status.der_skip || cnt == CNT_W'(DDIV_STEPS - 1)) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_STEP_MUL:  cmd.mul_en  = !status.n_lt2;
      ST_STEP_T:    cmd.t_en    = 1'b1;
      ST_STEP_LOAD: cmd.qd_load = 1'b1;
      ST_STEP_DIV:  cmd.qd_step = 1'b1;
      ST_STEP_UPD:  cmd.upd     = 1'b1;
      ST_DER_MUL1:  cmd.mul_en  = 1'b1;
      ST_DER_NUM:   cmd.num_en  = 1'b1;
      ST_DER_MUL2: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_sel_mu = 1'b1;
      end
      ST_DER_CHECK: cmd.chk_en   = 1'b1;
      ST_DER_DIV:   cmd.dd_step  = !status.der_skip;
      ST_FIN:       cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lpd_datapath.sv -----
// Datapath of the Legendre polynomial evaluator: rounding multiplier,
// recurrence term, divide-by-k unit, slope divider and output register.
// Depends on lpd_pkg; driven by lpd_ctrl through cmd_t and status_t.
`timescale 1ns / 1ps
`default_nettype none

module lpd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  lpd_pkg::cmd_t                       cmd,
  output lpd_pkg::status_t                    status,
  input  logic        [lpd_pkg::ORDER_W-1:0]  in_order,
  input  logic signed [lpd_pkg::MU_W-1:0]     in_mu,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [lpd_pkg::MU_W-1:0]     out_value,
  output logic signed [lpd_pkg::SLOPE_W-1:0]  out_slope,
  output logic                                out_sat
);
  import lpd_pkg::*;

  // Item registers.
  logic        [ORDER_W-1:0] n_r;
  logic        [ORDER_W-1:0] k_r;
  logic signed [MU_W-1:0]    mu_r;
  logic signed [MU_W-1:0]    cur;
  logic signed [MU_W-1:0]    prev;
  logic signed [MU_W-1:0]    prod;
  logic signed [QDIV_W-1:0]  t_r;

  // Divide-by-k unit.
  logic [QDIV_W-1:0]  u_sh;
  logic [QDIV_W-1:0]  q_sh;
  logic [ORDER_W-1:0] qrem;
  logic               t_neg;

  // Slope divider.
  logic signed [QDIV_W-1:0] num_r;
  logic [MU_W-2:0]          ud_r;
  logic [MU_W-2:0]          drem;
  logic [DDIV_STEPS-1:0]    dbits;
  logic [DDIV_STEPS-1:0]    dq;
  logic                     d_neg;
  logic                     d_zero;
  logic                     d_sat;

  // Rounding multiplier, sign and magnitude, half away from zero.
  logic signed [MU_W-1:0] mul_b;
  logic [MU_W-2:0]        mag_a;
  logic [MU_W-2:0]        mag_b;
  logic [2*MU_W-3:0]      mul_full;
  logic [2*MU_W-3:0]      mul_rnd;
  logic [MU_W-1:0]        mul_mag;
  logic signed [MU_W-1:0] mul_res;

  assign mul_b    = cmd.mul_sel_mu ? mu_r : cur;
  assign mag_a    = mu_r[MU_W-1]  ? (MU_W-1)'(-mu_r)  : mu_r[MU_W-2:0];
  assign mag_b    = mul_b[MU_W-1] ? (MU_W-1)'(-mul_b) : mul_b[MU_W-2:0];
  assign mul_full = mag_a * mag_b;
  assign mul_rnd  = mul_full + ((2*MU_W-2)'(1) << (FRAC_BITS - 1));
  assign mul_mag  = mul_rnd[FRAC_BITS +: MU_W];
  assign mul_res  = (mu_r[MU_W-1] ^ mul_b[MU_W-1]) ? -$signed(mul_mag) : $signed(mul_mag);

  // Input argument limited to [-1, 1].
  logic signed [MU_W-1:0] mu_clamp;

  always_comb begin
    if (in_mu > ONE_Q)       mu_clamp = ONE_Q;
    else if (in_mu < -ONE_Q) mu_clamp = -ONE_Q;
    else                     mu_clamp = in_mu;
  end

  // Recurrence numerator (2k-1)*mu*P(k-1) - (k-1)*P(k-2).
  logic [ORDER_W:0]         coef;
  logic [ORDER_W-1:0]       km1;
  logic signed [QDIV_W-1:0] a_term;
  logic signed [QDIV_W-1:0] b_term;
  logic [QDIV_W-1:0]        t_abs;

  assign coef   = {k_r, 1'b0} - (ORDER_W+1)'(1);
  assign km1    = k_r - ORDER_W'(1);
  assign a_term = $signed({1'b0, coef}) * prod;
  assign b_term = $signed({1'b0, km1}) * prev;
  assign t_abs  = t_r[QDIV_W-1] ? QDIV_W'(-t_r) : QDIV_W'(t_r);

  // Eight restoring steps against the narrow divisor k per cycle.
  logic [ORDER_W-1:0]   qrem_c;
  logic [ORDER_W:0]     qx;
  logic [QDIV_BITS-1:0] qbits;

  always_comb begin
    qrem_c = qrem;
    qbits  = '0;
    qx     = '0;
    for (int j = 0; j < QDIV_BITS; j++) begin
      qx = {qrem_c, u_sh[QDIV_W-1-j]};
      if (qx >= {1'b0, k_r}) begin
        qrem_c                 = ORDER_W'(qx - {1'b0, k_r});
        qbits[QDIV_BITS-1-j]   = 1'b1;
      end else begin
        qrem_c = qx[ORDER_W-1:0];
      end
    end
  end

  logic [MU_W-1:0]        q_clamp;
  logic signed [MU_W-1:0] step_val;

  assign q_clamp  = (q_sh > QDIV_W'(ONE_Q)) ? MU_W'(ONE_Q) : q_sh[MU_W-1:0];
  assign step_val = t_neg ? -$signed(q_clamp) : $signed(q_clamp);

  // Slope numerator and divider set-up.
  logic signed [MU_W:0]     diff;
  logic signed [QDIV_W-1:0] num_next;
  logic [MU_W-2:0]          ud_c;
  logic [QDIV_W-1:0]        un;
  logic [SLOPE_W-1:0]       sat_bound;
  logic                     big;

  assign diff      = {prod[MU_W-1], prod} - {prev[MU_W-1], prev};
  assign num_next  = $signed({1'b0, n_r}) * diff;
  assign ud_c      = (MU_W-1)'(ONE_Q - prod);
  assign un        = num_r[QDIV_W-1] ? QDIV_W'(-num_r) : QDIV_W'(num_r);
  // The integer part exceeds 2^11 exactly when un >= 2049 * ud.
  assign sat_bound = {ud_c, 11'b0} + SLOPE_W'(ud_c);
  assign big       = SLOPE_W'(un) >= sat_bound;

  logic [MU_W-1:0] dx;
  assign dx = {drem, dbits[DDIV_STEPS-1]};

  // Final slope: round the Q31 quotient, then limit.
  logic [DDIV_STEPS:0]   d_rnd;
  logic [DDIV_STEPS-1:0] d_lim;
  logic [DDIV_STEPS-1:0] s_mag;
  logic                  s_sat;
  logic [SLOPE_W-1:0]    s_val;

  assign d_rnd = {1'b0, dq} + (DDIV_STEPS+1)'(1);
  assign d_lim = d_neg ? (DDIV_STEPS'(1) << (SLOPE_W - 1))
                       : (DDIV_STEPS'(1) << (SLOPE_W - 1)) - DDIV_STEPS'(1);

  always_comb begin
    s_mag = '0;
    s_sat = 1'b0;
    if (n_r == ORDER_W'(0)) begin
      s_mag = '0;
    end else if (n_r == ORDER_W'(1)) begin
      s_mag = DDIV_STEPS'(ONE_Q);
    end else if (d_zero) begin
      s_mag = '0;
    end else if (d_sat || d_rnd[DDIV_STEPS:1] > d_lim) begin
      s_mag = d_lim;
      s_sat = 1'b1;
    end else begin
      s_mag = d_rnd[DDIV_STEPS:1];
    end
    // Order one is positive whatever the sign bookkeeping says.
    if (d_neg && n_r > ORDER_W'(1)) s_val = SLOPE_W'(-s_mag);
    else                             s_val = SLOPE_W'(s_mag);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= in_order;
      k_r  <= ORDER_W'(2);
      mu_r <= mu_clamp;
      cur  <= (in_order == ORDER_W'(0)) ? ONE_Q : mu_clamp;
      prev <= ONE_Q;
    end
    if (cmd.mul_en) prod <= mul_res;
    if (cmd.t_en)   t_r  <= a_term - b_term;
    if (cmd.qd_load) begin
      u_sh  <= t_abs + QDIV_W'(k_r[ORDER_W-1:1]);
      q_sh  <= '0;
      qrem  <= '0;
      t_neg <= t_r[QDIV_W-1];
    end
    if (cmd.qd_step) begin
      u_sh <= u_sh << QDIV_BITS;
      q_sh <= {q_sh[QDIV_W-QDIV_BITS-1:0], qbits};
      qrem <= qrem_c;
    end
    if (cmd.upd) begin
      prev <= cur;
      cur  <= step_val;
      k_r  <= k_r + ORDER_W'(1);
    end
    if (cmd.num_en) num_r <= num_next;
    if (cmd.chk_en) begin
      ud_r   <= ud_c;
      drem   <= (MU_W-1)'(un[QDIV_W-1:12]);
      dbits  <= {un[11:0], (DDIV_STEPS-12)'(0)};
      dq     <= '0;
      d_neg  <= !num_r[QDIV_W-1];
      d_zero <= (ud_c == '0);
      d_sat  <= (ud_c != '0) && big;
    end
    if (cmd.dd_step) begin
      dbits <= dbits << 1;
      if (dx >= {1'b0, ud_r}) begin
        drem <= (MU_W-1)'(dx - {1'b0, ud_r});
        dq   <= {dq[DDIV_STEPS-2:0], 1'b1};
      end else begin
        drem <= dx[MU_W-2:0];
        dq   <= {dq[DDIV_STEPS-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_value <= cur;
      out_slope <= $signed(s_val);
      out_sat   <= s_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.n_lt2    = (n_r < ORDER_W'(2));
  assign status.k_last   = (k_r == n_r);
  assign status.der_skip = d_zero | d_sat;
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/legendre_polynomial_with_derivative.sv -----
// Top level of the Legendre polynomial evaluator with derivative; uses lpd_pkg.
// Orders 0 and 1 take no recurrence step; order n >= 2 runs n-1 steps through the rounding
// multiplier, the recurrence term and the divide-by-k unit, then the one-bit-per-cycle
// slope divider, skipped when mu squared rounds to one or the slope saturates. A new
// transaction is taken only once the last result is loaded, and later while a result waits.
// Reset clears the controller and the output valid flag; no other state.
`timescale 1ns / 1ps
`default_nettype none

module legendre_polynomial_with_derivative (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // order [5:0], mu [37:6], zeros above
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // value [31:0], slope [73:32], zeros above
  output logic        m_axis_tuser   // slope_saturated
);
  import lpd_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic signed [MU_W-1:0]    value;
  logic signed [SLOPE_W-1:0] slope;

  lpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lpd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_order  (s_axis_tdata[ORDER_W-1:0]),
    .in_mu     ($signed(s_axis_tdata[ORDER_W +: MU_W])),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_value (value),
    .out_slope (slope),
    .out_sat   (m_axis_tuser)
  );

  assign m_axis_tdata = {6'b0, slope, value};

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for legendre_polynomial_with_derivative.
// A scoreboard class predicts value, slope and saturation flag from the order and the argument.
// Plain tasks drive the input stream with random gaps; a receiver process adds random stalls. Uses lpd_pkg.
`timescale 1ns / 1ps

module tb;
  import lpd_pkg::*;

  localparam int  RANDOM_ITEMS  = 850;
  localparam int  DRAIN_CYCLES  = 650;
  localparam int  HOLDOFF_LEN   = 800;
  localparam int  HOLDOFF_AT    = 200;
  localparam int  PAUSE_AT      = 500;
  localparam int  SHOWN_ERRORS  = 10;
  localparam longint UNIT_Q     = longint'(1) << FRAC_BITS;
  localparam logic [MU_W-1:0] MU_MAX_RAW = 32'h7FFF_FFFF;
  localparam logic [MU_W-1:0] MU_MIN_RAW = 32'h8000_0000;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  typedef struct {
    logic [ORDER_W-1:0]        order;
    logic [MU_W-1:0]           mu;
    logic signed [MU_W-1:0]    value;
    logic signed [SLOPE_W-1:0] slope;
    logic                      saturated;
  } legendre_result_t;

  class legendre_scoreboard;
    legendre_result_t pending[$];
    int accepted;
    int checked;
    int mismatches;
    int saturated_seen;

    function new();
      accepted = 0;
      checked = 0;
      mismatches = 0;
      saturated_seen = 0;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function longint clamp_unit(longint x);
      if (x > UNIT_Q) return UNIT_Q;
      if (x < -UNIT_Q) return -UNIT_Q;
      return x;
    endfunction

    // Exact product rounded to FRAC_BITS fraction bits, half away from zero.
    function longint round_mul(longint a, longint b);
      bit neg;
      longint unsigned ua, ub, p;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = (ua * ub + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return neg ? -longint'(p) : longint'(p);
    endfunction

    function longint round_div(longint x, longint k);
      longint unsigned ux, q;
      ux = (x < 0) ? -x : x;
      q = (ux + k / 2) / k;
      return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    // num / den with FRAC_BITS fraction bits, rounded, clamped to the slope width.
    function longint slope_quotient(longint num, longint den, output bit sat);
      bit neg;
      longint unsigned un, ud, lim, q, r;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      lim = neg ? (64'd1 << (SLOPE_W - 1)) : (64'd1 << (SLOPE_W - 1)) - 1;
      q = un / ud;
      r = un % ud;
      sat = 1'b0;
      if (q > (64'd1 << (SLOPE_W - 1 - FRAC_BITS))) begin
        q = lim;
        sat = 1'b1;
      end else begin
        for (int i = 0; i < FRAC_BITS; i++) begin
          r = r << 1;
          q = q << 1;
          if (r >= ud) begin
            r = r - ud;
            q = q | 1;
          end
        end
        r = r << 1;
        if (r >= ud) q = q + 1;
        if (q > lim) begin
          q = lim;
          sat = 1'b1;
        end
      end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    // Bonnet recurrence up to the order, then the derivative from the last two terms.
    // A six-bit order never exceeds the largest supported degree.
    function legendre_result_t evaluate(logic [ORDER_W-1:0] order, logic [MU_W-1:0] mu_raw);
      legendre_result_t res;
      longint mu, prev, cur, nxt, t, den, num, slope;
      int n;
      bit sat;
      mu = clamp_unit(longint'($signed(mu_raw)));
      n = order;
      slope = 0;
      sat = 1'b0;
      res.order = order;
      res.mu = mu_raw;
      if (n == 0) begin
        cur = UNIT_Q;
      end else begin
        prev = UNIT_Q;
        cur = mu;
        for (int k = 2; k <= n; k++) begin
          t = (2 * k - 1) * round_mul(mu, cur) - (k - 1) * prev;
          nxt = clamp_unit(round_div(t, k));
          prev = cur;
          cur = nxt;
        end
        if (n == 1) begin
          slope = UNIT_Q;
        end else if (mu != UNIT_Q && mu != -UNIT_Q) begin
          den = round_mul(mu, mu) - UNIT_Q;
          // A squared argument that rounds to one leaves the slope at zero.
          if (den < 0) begin
            num = n * (round_mul(mu, cur) - prev);
            slope = slope_quotient(num, den, sat);
          end
        end
      end
      res.value = cur[MU_W-1:0];
      res.slope = slope[SLOPE_W-1:0];
      res.saturated = sat;
      return res;
    endfunction

    function void note_input(logic [ORDER_W-1:0] order, logic [MU_W-1:0] mu);
      legendre_result_t res;
      res = evaluate(order, mu);
      accepted++;
      if (res.saturated) saturated_seen++;
      pending.push_back(res);
    endfunction

    function void check_result(logic [MU_W-1:0] value, logic [SLOPE_W-1:0] slope,
                               logic saturated);
      legendre_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("ERROR: unexpected result value %h slope %h sat %b", value, slope, saturated);
        return;
      end
      want = pending.pop_front();
      if (value !== want.value || slope !== want.slope || saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("ERROR: order %0d mu %h: value exp %h got %h, slope exp %h got %h, sat exp %b got %b",
                   want.order, want.mu, want.value, value, want.slope, slope,
                   want.saturated, saturated);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata = '0;  // order [5:0], mu [37:6], zeros above
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [79:0]         m_axis_tdata;       // value [31:0], slope [73:32], zeros above
  logic                m_axis_tuser;       // slope_saturated

  legendre_scoreboard sb = new();
  int holdoff_req = 0;
  int directed_sent = 0;

  legendre_polynomial_with_derivative DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  task automatic send_item(input logic [ORDER_W-1:0] order, input logic [MU_W-1:0] mu);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, mu, order};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(order, mu);
  endtask

  // Data is scrambled while valid is low; the block must ignore it.
  task automatic sender_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {8'($urandom), 32'($urandom)};
    end
  endtask

  function automatic logic [ORDER_W-1:0] random_order();
    if ($urandom_range(0, 3) == 0) return ORDER_W'($urandom_range(0, 63));
    return ORDER_W'($urandom_range(0, 12));
  endfunction

  function automatic logic [MU_W-1:0] random_mu();
    logic [MU_W-1:0] m;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0: m = ONE_Q;
          1: m = -ONE_Q;
          default: m = '0;
        endcase
      end
      1, 2: begin
        // Close to plus or minus one, where the slope denominator is tiny.
        m = ONE_Q - MU_W'($urandom_range(0, 5000));
        if ($urandom_range(0, 1)) m = -m;
      end
      3: m = $urandom;
      default: m = MU_W'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
    endcase
    return m;
  endfunction

  task automatic directed_items();
    send_item(0, '0);
    send_item(0, MU_MIN_RAW);
    send_item(0, MU_MAX_RAW);
    send_item(1, ONE_Q);
    send_item(1, -ONE_Q);
    send_item(1, '0);
    send_item(1, MU_MAX_RAW);
    send_item(2, ONE_Q);
    send_item(2, -ONE_Q);
    send_item(2, '0);
    send_item(2, ONE_Q - 1);
    send_item(2, -(ONE_Q - 1));
    send_item(63, ONE_Q);
    send_item(63, -ONE_Q);
    send_item(63, '0);
    send_item(63, ONE_Q - 1);
    send_item(63, -(ONE_Q - 1));
    send_item(63, MU_MIN_RAW);
    send_item(63, MU_MAX_RAW);
    send_item(3, ONE_Q >>> 1);
    send_item(5, -(ONE_Q / 3));
    send_item(40, ONE_Q - 1000);
    send_item(62, 32'd12345);
    directed_sent = sb.accepted;
  endtask

  // Receiver: changes its stall pattern now and then, and honours long hold-off requests.
  initial begin
    rx_mode_t mode;
    int left;
    int phase;
    int hold_left;
    mode = RX_ALWAYS;
    left = 0;
    phase = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holdoff_req > 0) begin
        hold_left = holdoff_req;
        holdoff_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 300);
        end
        left--;
        phase++;
        case (mode)
          RX_ALWAYS:   m_axis_tready <= 1'b1;
          RX_COIN:     m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: m_axis_tready <= ((phase % 7) >= 3);
          default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[31:0], m_axis_tdata[73:32], m_axis_tuser);
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int burst_left;
    int failures;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_items();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // The receiver holds off while transactions keep coming, so the input backs up.
      if (i == HOLDOFF_AT) holdoff_req = HOLDOFF_LEN;
      if (i == PAUSE_AT) begin
        sender_gap(1);
        while (sb.outstanding() != 0) @(posedge clk);
      end
      if (burst_left == 0) begin
        sender_gap($urandom_range(0, 12));
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      send_item(random_order(), random_mu());
    end
    sender_gap(1);

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    failures = sb.mismatches + sb.outstanding();
    $display("summary: %0d transactions in (%0d directed), %0d results compared, %0d with saturated slope",
             sb.accepted, directed_sent, sb.checked, sb.saturated_seen);
    $display("summary: %0d mismatches, %0d results never arrived", sb.mismatches, sb.outstanding());
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- legendre_polynomial_with_derivative.f -----
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_ctrl.sv
hw/rtl/lpd_datapath.sv
hw/rtl/legendre_polynomial_with_derivative.sv
tb/tb.sv
